// ===== hdl/camera_point_projection_defines.svh =====
// Assertion macros shared by the camera point projection checkers.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CAMERA_POINT_PROJECTION_DEFINES_SVH
`define CAMERA_POINT_PROJECTION_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define CPP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera point projection package
// Payload types of both item channels and the configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpp_pkg;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_X         = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Y         = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Z         = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAMERA_X      = 4'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAMERA_Y      = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAMERA_Z      = 4'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FOCAL_DEPTH   = 4'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_OFFSET = 4'd7;

    localparam logic [31:0] ROT_RESET   = 32'd16384;
    localparam logic [31:0] FOCAL_RESET = 32'd65536;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } cpp_in_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               depth_zero;
        logic               saturated;
    } cpp_out_t;

endpackage

// ===== hdl/camera_point_projection.sv =====
// ----------------------------------------------------------------------------
// Camera point projection
// Moves world points into camera space, rotates them and projects them onto
// the display plane in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
// An input item is one world point on in_data, taken when in_valid is high
// and in_stall is low. Each item yields exactly one result item on out_data,
// delivered when out_valid is high and out_stall is low.
// The configuration channel writes one register per cfg_valid and cfg_ready
// cycle; cfg_ready is always high. Writes must only occur while the pipeline
// holds no item. Indexes beyond the register list are ignored.
// Items pass through the camera offset, rotation, projection, divider, clip and output
// registers in order; one item is accepted every cycle while in_stall is low. The depth is
// set by the projection divider, which retires one quotient bit per stage.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the default camera registers.
`timescale 1ns / 1ps

module camera_point_projection #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  cpp_pkg::cpp_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output cpp_pkg::cpp_out_t                     out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cpp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [cpp_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import cpp_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = CW + 16;
    localparam int H   = (CW + 1) / 2;
    localparam int HH  = CW - H;
    localparam int NW  = 2 * CW;
    localparam int RW  = (CW + 3 > 33) ? CW + 3 : 33;
    localparam int LAT = CW + 13;

    typedef struct packed {
        logic [CW-1:0] rem_x;
        logic [CW-1:0] acc_x;
        logic [CW-1:0] rem_y;
        logic [CW-1:0] acc_y;
        logic [CW-1:0] den;
        logic          ovf_x;
        logic          ovf_y;
        logic          neg_x;
        logic          neg_y;
        logic          zero;
        logic          flag;
    } div_t;

    function automatic logic [CW:0] sat_cw(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        logic [CW:0]          r;
        hi = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi) r = {1'b1, hi[CW-1:0]};
        else if (v < lo) r = {1'b1, lo[CW-1:0]};
        else r = {1'b0, v[CW-1:0]};
        return r;
    endfunction

    function automatic logic [CW:0] rot_round(input logic signed [PW-1:0] p,
                                              input logic signed [PW-1:0] q,
                                              input logic sub);
        logic signed [PW:0] s;
        logic signed [PW:0] sh;
        if (sub) s = (PW+1)'(p) - (PW+1)'(q) + (PW+1)'(8192);
        else s = (PW+1)'(p) + (PW+1)'(q) + (PW+1)'(8192);
        sh = s >>> 14;
        return sat_cw(RW'(sh));
    endfunction

    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        return v[CW-1] ? (~v + CW'(1)) : v;
    endfunction

    function automatic div_t div_step(input div_t s);
        div_t          r;
        logic [CW:0]   tx;
        logic [CW:0]   ty;
        logic [CW:0]   dd;
        logic          gx;
        logic          gy;
        r  = s;
        dd = {1'b0, s.den};
        tx = {s.rem_x, s.acc_x[CW-1]};
        ty = {s.rem_y, s.acc_y[CW-1]};
        gx = (tx >= dd);
        gy = (ty >= dd);
        r.rem_x = gx ? CW'(tx - dd) : tx[CW-1:0];
        r.rem_y = gy ? CW'(ty - dd) : ty[CW-1:0];
        r.acc_x = {s.acc_x[CW-2:0], gx};
        r.acc_y = {s.acc_y[CW-2:0], gy};
        return r;
    endfunction

    // Configuration registers
    logic [31:0]          rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [CW-1:0] cam_x_reg, cam_y_reg, cam_z_reg, focal_reg;
    logic [63:0]          offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg  <= ROT_RESET;
            rot_y_reg  <= ROT_RESET;
            rot_z_reg  <= ROT_RESET;
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            focal_reg  <= CW'(FOCAL_RESET);
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROT_X:         rot_x_reg  <= cfg_data[31:0];
                REG_ROT_Y:         rot_y_reg  <= cfg_data[31:0];
                REG_ROT_Z:         rot_z_reg  <= cfg_data[31:0];
                REG_CAMERA_X:      cam_x_reg  <= cfg_data[CW-1:0];
                REG_CAMERA_Y:      cam_y_reg  <= cfg_data[CW-1:0];
                REG_CAMERA_Z:      cam_z_reg  <= cfg_data[CW-1:0];
                REG_FOCAL_DEPTH:   focal_reg  <= cfg_data[CW-1:0];
                REG_SCREEN_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [15:0] cx, sx, cy, sy, cz, sz;
    logic signed [31:0] off_x, off_y;

    assign cx    = rot_x_reg[15:0];
    assign sx    = rot_x_reg[31:16];
    assign cy    = rot_y_reg[15:0];
    assign sy    = rot_y_reg[31:16];
    assign cz    = rot_z_reg[15:0];
    assign sz    = rot_z_reg[31:16];
    assign off_x = offset_reg[31:0];
    assign off_y = offset_reg[63:32];

    // Pipeline control
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Stage 1: offset by camera position
    logic signed [CW-1:0] px, py, pz;
    logic [CW:0]          s1_x_next, s1_y_next, s1_z_next;
    logic signed [CW-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic                 s1_flag_reg;

    assign px = CW'($unsigned(in_data.point_x));
    assign py = CW'($unsigned(in_data.point_y));
    assign pz = CW'($unsigned(in_data.point_z));
    assign s1_x_next = sat_cw(RW'(px) - RW'(cam_x_reg));
    assign s1_y_next = sat_cw(RW'(py) - RW'(cam_y_reg));
    assign s1_z_next = sat_cw(RW'(pz) - RW'(cam_z_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= s1_x_next[CW-1:0];
            s1_y_reg    <= s1_y_next[CW-1:0];
            s1_z_reg    <= s1_z_next[CW-1:0];
            s1_flag_reg <= s1_x_next[CW] | s1_y_next[CW] | s1_z_next[CW];
        end
    end

    // Stages 2 and 3: rotation about z
    logic signed [PW-1:0] s2_p0_reg, s2_p1_reg, s2_p2_reg, s2_p3_reg;
    logic signed [CW-1:0] s2_z_reg;
    logic                 s2_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_p0_reg   <= s1_x_reg * cz;
            s2_p1_reg   <= s1_y_reg * sz;
            s2_p2_reg   <= s1_y_reg * cz;
            s2_p3_reg   <= s1_x_reg * sz;
            s2_z_reg    <= s1_z_reg;
            s2_flag_reg <= s1_flag_reg;
        end
    end

    logic [CW:0]          s3_x_next, s3_y_next;
    logic signed [CW-1:0] s3_x_reg, s3_y_reg, s3_z_reg;
    logic                 s3_flag_reg;

    assign s3_x_next = rot_round(s2_p0_reg, s2_p1_reg, 1'b0);
    assign s3_y_next = rot_round(s2_p2_reg, s2_p3_reg, 1'b1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_x_reg    <= s3_x_next[CW-1:0];
            s3_y_reg    <= s3_y_next[CW-1:0];
            s3_z_reg    <= s2_z_reg;
            s3_flag_reg <= s2_flag_reg | s3_x_next[CW] | s3_y_next[CW];
        end
    end

    // Stages 4 and 5: rotation about y
    logic signed [PW-1:0] s4_p0_reg, s4_p1_reg, s4_p2_reg, s4_p3_reg;
    logic signed [CW-1:0] s4_y_reg;
    logic                 s4_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_p0_reg   <= s3_x_reg * cy;
            s4_p1_reg   <= s3_z_reg * sy;
            s4_p2_reg   <= s3_x_reg * sy;
            s4_p3_reg   <= s3_z_reg * cy;
            s4_y_reg    <= s3_y_reg;
            s4_flag_reg <= s3_flag_reg;
        end
    end

    logic [CW:0]          s5_x_next, s5_z_next;
    logic signed [CW-1:0] s5_x_reg, s5_y_reg, s5_z_reg;
    logic                 s5_flag_reg;

    assign s5_x_next = rot_round(s4_p0_reg, s4_p1_reg, 1'b1);
    assign s5_z_next = rot_round(s4_p2_reg, s4_p3_reg, 1'b0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_x_reg    <= s5_x_next[CW-1:0];
            s5_z_reg    <= s5_z_next[CW-1:0];
            s5_y_reg    <= s4_y_reg;
            s5_flag_reg <= s4_flag_reg | s5_x_next[CW] | s5_z_next[CW];
        end
    end

    // Stages 6 and 7: rotation about x
    logic signed [PW-1:0] s6_p0_reg, s6_p1_reg, s6_p2_reg, s6_p3_reg;
    logic signed [CW-1:0] s6_x_reg;
    logic                 s6_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_p0_reg   <= s5_y_reg * cx;
            s6_p1_reg   <= s5_z_reg * sx;
            s6_p2_reg   <= s5_z_reg * cx;
            s6_p3_reg   <= s5_y_reg * sx;
            s6_x_reg    <= s5_x_reg;
            s6_flag_reg <= s5_flag_reg;
        end
    end

    logic [CW:0]          s7_y_next, s7_z_next;
    logic signed [CW-1:0] s7_x_reg, s7_y_reg, s7_z_reg;
    logic                 s7_flag_reg;

    assign s7_y_next = rot_round(s6_p0_reg, s6_p1_reg, 1'b0);
    assign s7_z_next = rot_round(s6_p2_reg, s6_p3_reg, 1'b1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_y_reg    <= s7_y_next[CW-1:0];
            s7_z_reg    <= s7_z_next[CW-1:0];
            s7_x_reg    <= s6_x_reg;
            s7_flag_reg <= s6_flag_reg | s7_y_next[CW] | s7_z_next[CW];
        end
    end

    // Projection, stage 8: magnitudes and result signs
    logic [CW-1:0] p1_f_reg, p1_x_reg, p1_y_reg, p1_d_reg;
    logic          p1_neg_x_reg, p1_neg_y_reg, p1_zero_reg, p1_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_f_reg     <= mag(focal_reg);
            p1_x_reg     <= mag(s7_x_reg);
            p1_y_reg     <= mag(s7_y_reg);
            p1_d_reg     <= mag(s7_z_reg);
            p1_neg_x_reg <= focal_reg[CW-1] ^ s7_x_reg[CW-1] ^ s7_z_reg[CW-1];
            p1_neg_y_reg <= focal_reg[CW-1] ^ s7_y_reg[CW-1] ^ s7_z_reg[CW-1];
            p1_zero_reg  <= (s7_z_reg == '0);
            p1_flag_reg  <= s7_flag_reg;
        end
    end

    // Stage 9: half-width partial products of focal times coordinate
    logic [2*H-1:0]  p2_x_ll_reg, p2_y_ll_reg;
    logic [CW-1:0]   p2_x_lh_reg, p2_x_hl_reg, p2_y_lh_reg, p2_y_hl_reg;
    logic [2*HH-1:0] p2_x_hh_reg, p2_y_hh_reg;
    logic [CW-1:0]   p2_d_reg;
    logic            p2_neg_x_reg, p2_neg_y_reg, p2_zero_reg, p2_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_x_ll_reg  <= p1_f_reg[H-1:0] * p1_x_reg[H-1:0];
            p2_x_lh_reg  <= p1_f_reg[H-1:0] * p1_x_reg[CW-1:H];
            p2_x_hl_reg  <= p1_f_reg[CW-1:H] * p1_x_reg[H-1:0];
            p2_x_hh_reg  <= p1_f_reg[CW-1:H] * p1_x_reg[CW-1:H];
            p2_y_ll_reg  <= p1_f_reg[H-1:0] * p1_y_reg[H-1:0];
            p2_y_lh_reg  <= p1_f_reg[H-1:0] * p1_y_reg[CW-1:H];
            p2_y_hl_reg  <= p1_f_reg[CW-1:H] * p1_y_reg[H-1:0];
            p2_y_hh_reg  <= p1_f_reg[CW-1:H] * p1_y_reg[CW-1:H];
            p2_d_reg     <= p1_d_reg;
            p2_neg_x_reg <= p1_neg_x_reg;
            p2_neg_y_reg <= p1_neg_y_reg;
            p2_zero_reg  <= p1_zero_reg;
            p2_flag_reg  <= p1_flag_reg;
        end
    end

    // Stage 10: sum of partial products
    logic [NW-1:0] p3_x_reg, p3_y_reg;
    logic [CW-1:0] p3_d_reg;
    logic          p3_neg_x_reg, p3_neg_y_reg, p3_zero_reg, p3_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_x_reg <= NW'(p2_x_ll_reg) + (NW'(p2_x_lh_reg) << H)
                      + (NW'(p2_x_hl_reg) << H) + (NW'(p2_x_hh_reg) << (2 * H));
            p3_y_reg <= NW'(p2_y_ll_reg) + (NW'(p2_y_lh_reg) << H)
                      + (NW'(p2_y_hl_reg) << H) + (NW'(p2_y_hh_reg) << (2 * H));
            p3_d_reg     <= p2_d_reg;
            p3_neg_x_reg <= p2_neg_x_reg;
            p3_neg_y_reg <= p2_neg_y_reg;
            p3_zero_reg  <= p2_zero_reg;
            p3_flag_reg  <= p2_flag_reg;
        end
    end

    // Stage 11: rounding bias and divider setup, then one quotient bit per stage
    logic [NW-1:0] n_x, n_y;
    div_t          div_next;
    div_t          div_reg [0:CW];

    assign n_x = p3_x_reg + NW'(p3_d_reg >> 1);
    assign n_y = p3_y_reg + NW'(p3_d_reg >> 1);

    always_comb
    begin
        div_next.rem_x = n_x[NW-1:CW];
        div_next.acc_x = n_x[CW-1:0];
        div_next.rem_y = n_y[NW-1:CW];
        div_next.acc_y = n_y[CW-1:0];
        div_next.den   = p3_d_reg;
        div_next.ovf_x = (n_x[NW-1:CW] >= p3_d_reg);
        div_next.ovf_y = (n_y[NW-1:CW] >= p3_d_reg);
        div_next.neg_x = p3_neg_x_reg;
        div_next.neg_y = p3_neg_y_reg;
        div_next.zero  = p3_zero_reg;
        div_next.flag  = p3_flag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= div_next;
        end
    end

    for (genvar k = 0; k < CW; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k+1] <= div_step(div_reg[k]);
            end
        end
    end

    // Clip the quotient and apply the sign
    div_t                 dq;
    logic [CW-1:0]        lim_x, lim_y, qx, qy;
    logic                 clip_x, clip_y;
    logic signed [CW:0]   f1_x_reg, f1_y_reg;
    logic                 f1_zero_reg, f1_flag_reg;

    assign dq     = div_reg[CW];
    assign lim_x  = {1'b0, {(CW-1){1'b1}}} + CW'(dq.neg_x);
    assign lim_y  = {1'b0, {(CW-1){1'b1}}} + CW'(dq.neg_y);
    assign clip_x = dq.ovf_x || (dq.acc_x > lim_x);
    assign clip_y = dq.ovf_y || (dq.acc_y > lim_y);
    assign qx     = clip_x ? lim_x : dq.acc_x;
    assign qy     = clip_y ? lim_y : dq.acc_y;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_x_reg    <= dq.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            f1_y_reg    <= dq.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            f1_zero_reg <= dq.zero;
            f1_flag_reg <= dq.flag | (!dq.zero && (clip_x || clip_y));
        end
    end

    // Output register: add display offsets and saturate; zero depth gives a zero position
    logic [CW:0] fx_next, fy_next;
    cpp_out_t    out_data_reg;

    assign fx_next = sat_cw(RW'(f1_x_reg) + RW'(off_x));
    assign fy_next = sat_cw(RW'(f1_y_reg) + RW'(off_y));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (f1_zero_reg)
            begin
                out_data_reg.screen_x  <= '0;
                out_data_reg.screen_y  <= '0;
                out_data_reg.depth_zero <= 1'b1;
                out_data_reg.saturated <= f1_flag_reg;
            end
            else
            begin
                out_data_reg.screen_x  <= 32'(fx_next[CW-1:0]);
                out_data_reg.screen_y  <= 32'(fy_next[CW-1:0]);
                out_data_reg.depth_zero <= 1'b0;
                out_data_reg.saturated <= f1_flag_reg | fx_next[CW] | fy_next[CW];
            end
        end
    end

    assign out_data = out_data_reg;

endmodule

// ===== hdl/cpp_checker.sv =====
// ----------------------------------------------------------------------------
// Camera point projection checker
// Port-level assertions on flow control and result items, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "camera_point_projection_defines.svh"

module cpp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input cpp_pkg::cpp_out_t out_data
);
    import cpp_pkg::*;

    `CPP_ASSERT_ALWAYS(a_stall_from_output, in_stall == (out_valid && out_stall), "input stall does not follow a blocked output item")
    `CPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output item changed")
    `CPP_ASSERT_ALWAYS(a_zero_depth, !(out_valid && out_data.depth_zero) || (out_data.screen_x == 32'sd0 && out_data.screen_y == 32'sd0), "zero depth item has nonzero screen position")

endmodule

bind camera_point_projection cpp_checker u_cpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/camera_point_projection_tb.sv =====
// ----------------------------------------------------------------------------
// Camera point projection testbench
// Drives world points through the projection pipeline under random idling and
// long output stalls, predicts every screen point in fixed point and compares
// each result field by field. Registers are rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_point_projection_tb;
    import cpp_pkg::*;

    localparam int LATENCY     = 45;
    localparam int WATCH_LIMIT = 20000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    cpp_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    cpp_out_t         out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    logic [63:0]      reg_file [0:7];
    cpp_out_t         expected_points [$];
    int               error_count;
    int               idle_cycles;
    int               points_sent;
    int               points_checked;
    int               zero_depth_seen;
    int               clip_seen;
    bit               hold_output;

    camera_point_projection i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clip32(longint v, ref bit clipped);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint rotate_term(longint a, longint ca, longint b, longint cb,
                                           ref bit clipped);
        longint p;
        longint q;
        p = a * ca;
        q = b * cb;
        return clip32((p + q + 64'sd8192) >>> 14, clipped);
    endfunction

    function automatic longint project_axis(longint f, longint r, longint z,
                                            ref bit clipped);
        logic signed [127:0] num;
        logic [127:0]        mag_num;
        logic [127:0]        mag_den;
        logic [127:0]        quot;
        bit                  neg;
        longint              lim;
        num = 128'(f) * 128'(r);
        neg = num[127] != (z < 0);
        mag_num = num[127] ? -num : num;
        mag_den = (z < 0) ? 128'(-z) : 128'(z);
        quot = (mag_num + (mag_den >> 1)) / mag_den;
        lim = neg ? 64'sd2147483648 : 64'sd2147483647;
        if (quot > 128'(lim))
        begin
            clipped = 1'b1;
            quot = 128'(lim);
        end
        return neg ? -longint'(quot) : longint'(quot);
    endfunction

    function automatic cpp_out_t predict_screen_point(cpp_in_t p);
        cpp_out_t res;
        bit       clipped;
        longint   cxr, sxr, cyr, syr, czr, szr;
        longint   dx, dy, dz, x1, y1, x2, z2, y3, z3, sx, sy;
        clipped = 1'b0;
        cxr = longint'($signed(reg_file[REG_ROT_X][15:0]));
        sxr = longint'($signed(reg_file[REG_ROT_X][31:16]));
        cyr = longint'($signed(reg_file[REG_ROT_Y][15:0]));
        syr = longint'($signed(reg_file[REG_ROT_Y][31:16]));
        czr = longint'($signed(reg_file[REG_ROT_Z][15:0]));
        szr = longint'($signed(reg_file[REG_ROT_Z][31:16]));
        dx = clip32(longint'(p.point_x)
                    - longint'($signed(reg_file[REG_CAMERA_X][31:0])), clipped);
        dy = clip32(longint'(p.point_y)
                    - longint'($signed(reg_file[REG_CAMERA_Y][31:0])), clipped);
        dz = clip32(longint'(p.point_z)
                    - longint'($signed(reg_file[REG_CAMERA_Z][31:0])), clipped);
        x1 = rotate_term(dx, czr, dy, szr, clipped);
        y1 = rotate_term(dx, -szr, dy, czr, clipped);
        x2 = rotate_term(x1, cyr, dz, -syr, clipped);
        z2 = rotate_term(x1, syr, dz, cyr, clipped);
        y3 = rotate_term(y1, cxr, z2, sxr, clipped);
        z3 = rotate_term(y1, -sxr, z2, cxr, clipped);
        sx = 0;
        sy = 0;
        if (z3 != 0)
        begin
            sx = clip32(project_axis(longint'($signed(reg_file[REG_FOCAL_DEPTH][31:0])),
                                     x2, z3, clipped)
                        + longint'($signed(reg_file[REG_SCREEN_OFFSET][31:0])), clipped);
            sy = clip32(project_axis(longint'($signed(reg_file[REG_FOCAL_DEPTH][31:0])),
                                     y3, z3, clipped)
                        + longint'($signed(reg_file[REG_SCREEN_OFFSET][63:32])), clipped);
        end
        res.screen_x   = sx[31:0];
        res.screen_y   = sy[31:0];
        res.depth_zero = (z3 == 0);
        res.saturated  = clipped;
        return res;
    endfunction

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [63:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < 8)
            reg_file[idx] = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(cpp_in_t p);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_data  <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_points = {expected_points, predict_screen_point(p)};
        points_sent++;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);
    endtask

    function automatic cpp_in_t random_point(int spread);
        cpp_in_t p;
        p.point_x = $urandom;
        p.point_y = $urandom;
        p.point_z = $urandom;
        if (spread == 0)
        begin
            p.point_x = $signed(p.point_x) >>> 10;
            p.point_y = $signed(p.point_y) >>> 10;
            p.point_z = ($signed(p.point_z) >>> 10) + 32'sd1048576;
        end
        return p;
    endfunction

    function automatic logic [31:0] angle_pair(real a);
        logic [15:0] c;
        logic [15:0] s;
        c = 16'($rtoi($cos(a) * 16384.0));
        s = 16'($rtoi($sin(a) * 16384.0));
        return {s, c};
    endfunction

    task automatic test_directed_points();
        cpp_in_t p;
        p = '{32'sd0, 32'sd0, 32'sd0};
        send_point(p);
        p = '{32'sd65536, 32'sd131072, 32'sd65536};
        send_point(p);
        p = '{32'sd65536, -32'sd65536, -32'sd131072};
        send_point(p);
        p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        send_point(p);
        p = '{32'h80000000, 32'h80000000, 32'h80000000};
        send_point(p);
        p = '{32'h7fffffff, 32'h80000000, 32'sd1};
        send_point(p);
        p = '{32'sd1, -32'sd1, 32'sd3};
        send_point(p);
        p = '{32'sd3, 32'sd5, 32'sd2};
        send_point(p);
        p = '{32'hffffffff, 32'h00000000, 32'hffffffff};
        send_point(p);
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        cpp_in_t p;
        write_register(REG_ROT_X, 64'h0000_8000_8000);
        write_register(REG_ROT_Y, 64'h0000_7fff_7fff);
        write_register(REG_ROT_Z, 64'h0000_ffff_0000);
        write_register(REG_CAMERA_X, 64'h8000_0000);
        write_register(REG_CAMERA_Y, 64'h7fff_ffff);
        write_register(REG_CAMERA_Z, 64'hffff_ffff);
        write_register(REG_FOCAL_DEPTH, 64'h7fff_ffff);
        write_register(REG_SCREEN_OFFSET, 64'h7fff_ffff_8000_0000);
        write_register(4'd12, 64'hdead_beef);
        p = '{32'h7fffffff, 32'h80000000, 32'sd5};
        send_point(p);
        p = '{32'sd0, 32'sd0, 32'sd1};
        send_point(p);
        p = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        send_point(p);
        drain_pipeline();
        write_register(REG_FOCAL_DEPTH, 64'h8000_0000);
        write_register(REG_SCREEN_OFFSET, 64'h8000_0000_7fff_ffff);
        p = '{32'sd12345, -32'sd999, 32'sd77};
        send_point(p);
        p = '{32'sd0, 32'sd0, 32'sd0};
        send_point(p);
        drain_pipeline();
    endtask

    task automatic test_random_points(int count, int spread);
        for (int i = 0; i < count; i++)
            send_point(random_point(spread));
        drain_pipeline();
    endtask

    task automatic load_camera(bit wide);
        write_register(REG_ROT_X, 64'(angle_pair($urandom_range(0, 6283) / 1000.0)));
        write_register(REG_ROT_Y, 64'(angle_pair($urandom_range(0, 6283) / 1000.0)));
        write_register(REG_ROT_Z, wide ? 64'($urandom)
                                       : 64'(angle_pair($urandom_range(0, 6283) / 1000.0)));
        write_register(REG_CAMERA_X, wide ? 64'($urandom) : 64'($signed($urandom) >>> 12));
        write_register(REG_CAMERA_Y, wide ? 64'($urandom) : 64'($signed($urandom) >>> 12));
        write_register(REG_CAMERA_Z, wide ? 64'($urandom) : 64'($signed($urandom) >>> 12));
        write_register(REG_FOCAL_DEPTH, wide ? 64'($urandom)
                                             : 64'($urandom_range(32768, 4194304)));
        write_register(REG_SCREEN_OFFSET, {$urandom, $urandom});
    endtask

    task automatic test_backpressure();
        hold_output = 1'b1;
        for (int i = 0; i < 80; i++)
            send_point(random_point(0));
        hold_output = 1'b0;
        drain_pipeline();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_output)
        begin
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        hold_output = 1'b0;
        wait (rst_n);
        forever
        begin
            wait (hold_output);
            repeat (200)
                @(posedge clk);
            hold_output = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                error_count++;
            end
            else
            begin
                cpp_out_t want;
                want = expected_points.pop_front();
                points_checked++;
                zero_depth_seen += want.depth_zero;
                clip_seen += want.saturated;
                if (out_data.screen_x !== want.screen_x)
                begin
                    $display("%0t: screen_x expected %h actual %h",
                             $time, want.screen_x, out_data.screen_x);
                    error_count++;
                end
                if (out_data.screen_y !== want.screen_y)
                begin
                    $display("%0t: screen_y expected %h actual %h",
                             $time, want.screen_y, out_data.screen_y);
                    error_count++;
                end
                if (out_data.depth_zero !== want.depth_zero)
                begin
                    $display("%0t: depth_zero expected %b actual %b",
                             $time, want.depth_zero, out_data.depth_zero);
                    error_count++;
                end
                if (out_data.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, out_data.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", expected_points.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        error_count     = 0;
        idle_cycles     = 0;
        points_sent     = 0;
        points_checked  = 0;
        zero_depth_seen = 0;
        clip_seen       = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reg_file[REG_ROT_X]         = 64'(ROT_RESET);
        reg_file[REG_ROT_Y]         = 64'(ROT_RESET);
        reg_file[REG_ROT_Z]         = 64'(ROT_RESET);
        reg_file[REG_CAMERA_X]      = '0;
        reg_file[REG_CAMERA_Y]      = '0;
        reg_file[REG_CAMERA_Z]      = '0;
        reg_file[REG_FOCAL_DEPTH]   = 64'(FOCAL_RESET);
        reg_file[REG_SCREEN_OFFSET] = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_points();
        test_register_extremes();
        load_camera(1'b0);
        test_random_points(150, 0);
        test_backpressure();
        load_camera(1'b1);
        test_random_points(100, 1);
        load_camera(1'b0);
        test_random_points(150, 0);

        $display("Checked %0d of %0d points over several camera setups", points_checked,
                 points_sent);
        $display("Zero-depth results: %0d, clipped results: %0d", zero_depth_seen, clip_seen);
        if (error_count == 0 && expected_points.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
